// ===== src/wrhp_pkg.sv =====
// Shared types and constants for the WAV RIFF header parser.
package wrhp_pkg;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FMT_ERR = 2'd1;
    localparam logic [1:0] ST_BAD_WIDTH = 2'd2;

    localparam logic [31:0] TAG_RIFF = 32'h52494646;
    localparam logic [31:0] TAG_WAVE = 32'h57415645;
    localparam logic [31:0] TAG_FMT = 32'h666D7420;
    localparam logic [31:0] TAG_DATA = 32'h64617461;
    localparam logic [31:0] FMT_CORE_BYTES = 32'd16;
    localparam logic [15:0] BITS_8 = 16'd8;
    localparam logic [15:0] BITS_16 = 16'd16;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] format_tag;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] frame_align;
        logic [15:0] sample_bits;
        logic [31:0] payload_offset;
        logic [31:0] payload_size;
    } t_out_item;

endpackage

// ===== src/wrhp_parser.sv =====
// Front part: byte-wise RIFF/WAVE header parser, emits at most one result per byte.
module wrhp_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  wrhp_pkg::t_in_item  i_item,
    output logic                o_res_valid,
    output wrhp_pkg::t_out_item o_res
);
    import wrhp_pkg::*;

    localparam logic [3:0] PH_RIFF_TAG = 4'd0;
    localparam logic [3:0] PH_RIFF_SIZE = 4'd1;
    localparam logic [3:0] PH_WAVE_TAG = 4'd2;
    localparam logic [3:0] PH_CHUNK_ID = 4'd3;
    localparam logic [3:0] PH_CHUNK_SIZE = 4'd4;
    localparam logic [3:0] PH_FMT_BODY = 4'd5;
    localparam logic [3:0] PH_SKIP_BODY = 4'd6;
    localparam logic [3:0] PH_PAD = 4'd7;
    localparam logic [3:0] PH_HOLD = 4'd8;

    logic [3:0]   r_phase, n_phase;
    logic [1:0]   r_idx, n_idx;
    logic [31:0]  r_tag, n_tag;
    logic [31:0]  r_size, n_size;
    logic [31:0]  r_skip, n_skip;
    logic [31:0]  r_off, n_off;
    logic [127:0] r_fmt, n_fmt;
    logic         r_found_fmt, n_found_fmt;
    logic         r_found_pay, n_found_pay;
    logic [63:0]  r_pay, n_pay;
    logic         r_done, n_done;

    logic [7:0]  b;
    logic [31:0] pos;
    logic [15:0] bits;
    logic        emit_hdr, emit_err;

    always_comb begin
        b = i_item.data_byte;
        n_phase = r_phase;
        n_idx = r_idx;
        n_tag = r_tag;
        n_size = r_size;
        n_skip = r_skip;
        n_off = r_off + 32'd1;
        n_fmt = r_fmt;
        n_found_fmt = r_found_fmt;
        n_found_pay = r_found_pay;
        n_pay = r_pay;
        n_done = r_done;
        emit_hdr = 1'b0;
        emit_err = 1'b0;
        pos = r_size - r_skip;
        case (r_phase)
            PH_RIFF_TAG, PH_WAVE_TAG, PH_CHUNK_ID: begin
                n_tag = {r_tag[23:0], b};
                n_idx = r_idx + 2'd1;
                if (n_idx == 2'd0) begin
                    if (r_phase == PH_RIFF_TAG) begin
                        if (n_tag == TAG_RIFF) n_phase = PH_RIFF_SIZE;
                        else emit_err = 1'b1;
                    end else if (r_phase == PH_WAVE_TAG) begin
                        if (n_tag == TAG_WAVE) n_phase = PH_CHUNK_ID;
                        else emit_err = 1'b1;
                    end else begin
                        n_phase = PH_CHUNK_SIZE;
                    end
                end
            end
            PH_RIFF_SIZE: begin
                n_idx = r_idx + 2'd1;
                if (n_idx == 2'd0) n_phase = PH_WAVE_TAG;
            end
            PH_CHUNK_SIZE: begin
                n_size = {b, r_size[31:8]};
                n_idx = r_idx + 2'd1;
                if (n_idx == 2'd0) begin
                    if (!r_found_fmt && r_tag == TAG_FMT) begin
                        if (n_size < FMT_CORE_BYTES) begin
                            emit_err = 1'b1;
                        end else begin
                            n_skip = n_size;
                            n_phase = PH_FMT_BODY;
                        end
                    end else begin
                        if (!r_found_pay && r_tag == TAG_DATA) begin
                            n_pay = {n_size, r_off + 32'd1};
                            n_found_pay = 1'b1;
                            if (r_found_fmt) emit_hdr = 1'b1;
                        end
                        if (!emit_hdr) begin
                            n_skip = n_size;
                            if (n_size == 32'd0)
                                n_phase = n_size[0] ? PH_PAD : PH_CHUNK_ID;
                            else
                                n_phase = PH_SKIP_BODY;
                        end
                    end
                end
            end
            PH_FMT_BODY: begin
                if (pos < FMT_CORE_BYTES) n_fmt[pos[3:0]*8 +: 8] = b;
                n_skip = r_skip - 32'd1;
                if (n_skip == 32'd0) begin
                    n_found_fmt = 1'b1;
                    if (r_found_pay) emit_hdr = 1'b1;
                    else n_phase = r_size[0] ? PH_PAD : PH_CHUNK_ID;
                end
            end
            PH_SKIP_BODY: begin
                n_skip = r_skip - 32'd1;
                if (n_skip == 32'd0) n_phase = r_size[0] ? PH_PAD : PH_CHUNK_ID;
            end
            PH_PAD: n_phase = PH_CHUNK_ID;
            default: ;
        endcase
        if (emit_hdr || emit_err) begin
            n_phase = PH_HOLD;
            n_done = 1'b1;
        end
        if (i_item.end_of_stream && !emit_hdr && !r_done) emit_err = 1'b1;
    end

    assign bits = n_fmt[127:112];

    always_comb begin
        o_res = '0;
        o_res_valid = i_valid && (emit_hdr || emit_err);
        if (emit_err) begin
            o_res.status = ST_FMT_ERR;
        end else begin
            o_res.status = (bits == BITS_8 || bits == BITS_16) ? ST_OK : ST_BAD_WIDTH;
            o_res.format_tag = n_fmt[15:0];
            o_res.channel_count = n_fmt[31:16];
            o_res.sample_rate = n_fmt[63:32];
            o_res.byte_rate = n_fmt[95:64];
            o_res.frame_align = n_fmt[111:96];
            o_res.sample_bits = bits;
            o_res.payload_offset = n_pay[31:0];
            o_res.payload_size = n_pay[63:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && i_item.end_of_stream)) begin
            r_phase <= PH_RIFF_TAG;
            r_idx <= '0;
            r_tag <= '0;
            r_size <= '0;
            r_skip <= '0;
            r_off <= '0;
            r_fmt <= '0;
            r_found_fmt <= 1'b0;
            r_found_pay <= 1'b0;
            r_pay <= '0;
            r_done <= 1'b0;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_idx <= n_idx;
            r_tag <= n_tag;
            r_size <= n_size;
            r_skip <= n_skip;
            r_off <= n_off;
            r_fmt <= n_fmt;
            r_found_fmt <= n_found_fmt;
            r_found_pay <= n_found_pay;
            r_pay <= n_pay;
            r_done <= n_done;
        end
    end

`ifndef SYNTH
    a_hold_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HOLD) |-> r_done) else $error("hold without done");
    a_done_no_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !emit_hdr) else $error("second header");
    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == ST_FMT_ERR) |-> (o_res.payload_size == 32'd0))
        else $error("error result carries fields");
`endif
endmodule

// ===== src/wrhp_queue.sv =====
// Back part: small result queue decoupling the parser from the output handshake.
module wrhp_queue #(
    parameter int DEPTH = wrhp_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  wrhp_pkg::t_out_item i_data,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_ready,
    output wrhp_pkg::t_out_item o_data
);
    import wrhp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_out_item      r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;
    logic           pop;

    assign pop = o_valid && i_ready;
    assign o_valid = r_cnt != '0;
    assign o_full = r_cnt == (AW+1)'(DEPTH);
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (pop) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(pop);
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || pop) else $error("queue overflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("count out of range");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_push) |=> r_cnt == $past(r_cnt) - 1'b1) else $error("pop lost");
`endif
endmodule

// ===== src/wav_riff_header_parser.sv =====
// Top level of the WAV RIFF header parser.
//  channel | valid    | ready    | payload
//  input   | i_valid  | o_ready  | i_item  (byte, end of stream)
//  output  | o_valid  | i_ready  | o_item  (status and header fields)
// One byte per cycle while the queue is not full; each byte is parsed in the cycle it is accepted.
// A result is registered into a DEPTH-entry queue (two by default) and offered in order from its head.
// Input stalls whenever the queue is full, even if it drains in that cycle.
// Synchronous active-low reset; end_of_stream rearms the parser.
module wav_riff_header_parser #(
    parameter int DEPTH = wrhp_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  wrhp_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output wrhp_pkg::t_out_item o_item
);
    import wrhp_pkg::*;

    logic      acc, res_valid, full;
    t_out_item res;

    assign o_ready = !full;
    assign acc = i_valid && o_ready;

    wrhp_parser u_parser (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(acc), .i_item(i_item),
        .o_res_valid(res_valid), .o_res(res)
    );

    wrhp_queue #(.DEPTH(DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(res_valid), .i_data(res),
        .o_full(full), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_item)
    );
endmodule

// ===== tb/wav_riff_header_parser_tb.sv =====
// Testbench for the WAV RIFF header parser: WAV byte streams in, header results checked.
module wav_riff_header_parser_tb;
    import wrhp_pkg::*;

    typedef enum logic [3:0] {
        P_RIFF, P_RSIZE, P_WAVE, P_ID, P_SIZE, P_FMT, P_SKIP, P_PAD, P_HOLD
    } t_phase;

    typedef enum int {
        F_FMT_FIRST, F_DATA_FIRST, F_BAD_RIFF, F_BAD_WAVE, F_SHORT_FMT, F_EARLY_END, F_NOISE
    } t_file_kind;

    localparam int CYCLE_LIMIT = 200000;
    localparam int CALM_START = 600;
    localparam int CALM_END = 1000;
    localparam int HOLD_AT = 1300;
    localparam int HOLD_LEN = 300;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_item = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_item;

    wav_riff_header_parser u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_item(i_item),
        .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item)
    );

    t_in_item  byte_q[$];
    t_out_item header_q[$];
    int        err_count = 0;
    int        cycle = 0;
    int        hold_left = 0;
    bit        in_fire = 1'b0;

    // parser model state
    t_phase      phase;
    logic [1:0]  byte_idx;
    logic [31:0] tag_sr, size_sr, skip_left, offset, data_off, data_len;
    logic [7:0]  fmt_b[16];
    bit          have_fmt, have_data, finished;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void clear_parser();
        phase = P_RIFF;
        byte_idx = '0;
        tag_sr = '0;
        size_sr = '0;
        skip_left = '0;
        offset = '0;
        data_off = '0;
        data_len = '0;
        for (int k = 0; k < 16; k++) fmt_b[k] = '0;
        have_fmt = 0;
        have_data = 0;
        finished = 0;
    endfunction

    function automatic logic [31:0] fmt_le(int pos, int n);
        logic [31:0] v = '0;
        for (int k = 0; k < n; k++) v |= 32'(fmt_b[pos + k]) << (8 * k);
        return v;
    endfunction

    function automatic bit fail(output t_out_item r);
        r = '0;
        r.status = ST_FMT_ERR;
        phase = P_HOLD;
        finished = 1;
        return 1;
    endfunction

    function automatic bit header_out(output t_out_item r);
        r.sample_bits = fmt_le(14, 2);
        r.status = (r.sample_bits == BITS_8 || r.sample_bits == BITS_16) ? ST_OK : ST_BAD_WIDTH;
        r.format_tag = fmt_le(0, 2);
        r.channel_count = fmt_le(2, 2);
        r.sample_rate = fmt_le(4, 4);
        r.byte_rate = fmt_le(8, 4);
        r.frame_align = fmt_le(12, 2);
        r.payload_offset = data_off;
        r.payload_size = data_len;
        phase = P_HOLD;
        finished = 1;
        return 1;
    endfunction

    function automatic void body_done();
        phase = size_sr[0] ? P_PAD : P_ID;
    endfunction

    function automatic bit open_chunk(output t_out_item r);
        r = '0;
        if (!have_fmt && tag_sr == TAG_FMT) begin
            if (size_sr < FMT_CORE_BYTES) return fail(r);
            skip_left = size_sr;
            phase = P_FMT;
            return 0;
        end
        if (!have_data && tag_sr == TAG_DATA) begin
            data_len = size_sr;
            data_off = offset + 1;
            have_data = 1;
            if (have_fmt) return header_out(r);
        end
        skip_left = size_sr;
        if (size_sr == 0) body_done();
        else phase = P_SKIP;
        return 0;
    endfunction

    function automatic bit parse_byte(input t_in_item it, output t_out_item r);
        bit got = 0;
        logic [31:0] pos;
        r = '0;
        case (phase)
            P_RIFF, P_WAVE, P_ID: begin
                tag_sr = {tag_sr[23:0], it.data_byte};
                byte_idx++;
                if (byte_idx == 0) begin
                    if (phase == P_RIFF) begin
                        if (tag_sr == TAG_RIFF) phase = P_RSIZE;
                        else got = fail(r);
                    end else if (phase == P_WAVE) begin
                        if (tag_sr == TAG_WAVE) phase = P_ID;
                        else got = fail(r);
                    end else begin
                        phase = P_SIZE;
                    end
                end
            end
            P_RSIZE: begin
                byte_idx++;
                if (byte_idx == 0) phase = P_WAVE;
            end
            P_SIZE: begin
                size_sr = {it.data_byte, size_sr[31:8]};
                byte_idx++;
                if (byte_idx == 0) got = open_chunk(r);
            end
            P_FMT: begin
                pos = size_sr - skip_left;
                if (pos < FMT_CORE_BYTES) fmt_b[pos[3:0]] = it.data_byte;
                skip_left--;
                if (skip_left == 0) begin
                    have_fmt = 1;
                    if (have_data) got = header_out(r);
                    else body_done();
                end
            end
            P_SKIP: begin
                skip_left--;
                if (skip_left == 0) body_done();
            end
            P_PAD: phase = P_ID;
            default: ;
        endcase
        offset++;
        if (it.end_of_stream) begin
            if (!got && !finished) got = fail(r);
            clear_parser();
        end
        return got;
    endfunction

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", field, got, want);
        err_count++;
    endtask

    task automatic check_header(t_out_item got, t_out_item want);
        if (got.status !== want.status) report("status", got.status, want.status);
        if (got.format_tag !== want.format_tag)
            report("format_tag", got.format_tag, want.format_tag);
        if (got.channel_count !== want.channel_count)
            report("channel_count", got.channel_count, want.channel_count);
        if (got.sample_rate !== want.sample_rate)
            report("sample_rate", got.sample_rate, want.sample_rate);
        if (got.byte_rate !== want.byte_rate) report("byte_rate", got.byte_rate, want.byte_rate);
        if (got.frame_align !== want.frame_align)
            report("frame_align", got.frame_align, want.frame_align);
        if (got.sample_bits !== want.sample_bits)
            report("sample_bits", got.sample_bits, want.sample_bits);
        if (got.payload_offset !== want.payload_offset)
            report("payload_offset", got.payload_offset, want.payload_offset);
        if (got.payload_size !== want.payload_size)
            report("payload_size", got.payload_size, want.payload_size);
    endtask

    // stream builders
    task automatic put(logic [7:0] b, logic eos = 1'b0);
        t_in_item it;
        it.data_byte = b;
        it.end_of_stream = eos;
        byte_q.push_back(it);
    endtask

    task automatic put_tag(logic [31:0] t);
        for (int k = 3; k >= 0; k--) put(t[8*k +: 8]);
    endtask

    task automatic put_le32(logic [31:0] v);
        for (int k = 0; k < 4; k++) put(v[8*k +: 8]);
    endtask

    task automatic put_random(int n);
        for (int k = 0; k < n; k++) put(8'($urandom));
    endtask

    task automatic put_fmt(int fill);
        logic [31:0] sz;
        logic [15:0] bits;
        sz = FMT_CORE_BYTES + $urandom_range(3);
        put_tag(TAG_FMT);
        put_le32(sz);
        case ($urandom_range(3))
            0: bits = BITS_8;
            1: bits = BITS_16;
            default: bits = 16'($urandom);
        endcase
        for (int k = 0; k < 14; k++) put(fill >= 0 ? 8'(fill) : 8'($urandom));
        if (fill >= 0) bits = {2{8'(fill)}};
        put(bits[7:0]);
        put(bits[15:8]);
        put_random(sz - FMT_CORE_BYTES);
        if (sz[0]) put(8'($urandom));
    endtask

    task automatic put_junk();
        logic [31:0] id, sz;
        id = $urandom;
        if (id == TAG_FMT || id == TAG_DATA) id ^= 32'h1;
        sz = $urandom_range(5);
        put_tag(id);
        put_le32(sz);
        put_random(sz + sz[0]);
    endtask

    task automatic put_tail();
        put_random($urandom_range(3));
        put(8'($urandom), 1'b1);
    endtask

    task automatic put_file(t_file_kind kind, int fill = -1);
        logic [31:0] sz;
        case (kind)
            F_NOISE: begin
                put_random($urandom_range(30));
                put(8'($urandom), 1'b1);
                return;
            end
            F_BAD_RIFF: begin
                put_tag(TAG_RIFF ^ (32'h1 << $urandom_range(31)));
                put_tail();
                return;
            end
            default: ;
        endcase
        put_tag(TAG_RIFF);
        put_le32($urandom);
        if (kind == F_BAD_WAVE) begin
            put_tag(TAG_WAVE ^ (32'h1 << $urandom_range(31)));
            put_tail();
            return;
        end
        put_tag(TAG_WAVE);
        if ($urandom_range(1)) put_junk();
        case (kind)
            F_FMT_FIRST: begin
                put_fmt(fill);
                if ($urandom_range(1)) put_junk();
                put_tag(TAG_DATA);
                put_le32(fill >= 0 ? {4{8'(fill)}} : $urandom);
            end
            F_DATA_FIRST: begin
                sz = $urandom_range(5);
                put_tag(TAG_DATA);
                put_le32(sz);
                put_random(sz + sz[0]);
                if ($urandom_range(1)) put_junk();
                put_fmt(fill);
            end
            F_SHORT_FMT: begin
                put_tag(TAG_FMT);
                put_le32($urandom_range(15));
            end
            default: put_random($urandom_range(20));
        endcase
        put_tail();
    endtask

    task automatic wait_drained();
        while (byte_q.size() != 0 || i_valid || header_q.size() != 0) @(posedge i_clk);
    endtask

    // cycle count, timeout, input acceptance and prediction
    always @(posedge i_clk) begin
        t_out_item r;
        cycle <= cycle + 1;
        if (cycle >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            in_fire <= i_valid && o_ready;
            if (i_rst_n && i_valid && o_ready) begin
                if (parse_byte(i_item, r)) header_q.push_back(r);
            end
        end
    end

    // sender
    always @(negedge i_clk) begin
        bit calm;
        calm = cycle >= CALM_START && cycle < CALM_END;
        if (i_rst_n && (!i_valid || in_fire)) begin
            if (byte_q.size() != 0 && (calm || $urandom_range(99) >= 38)) begin
                i_item <= byte_q.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off
    always @(negedge i_clk) begin
        if (cycle == HOLD_AT) hold_left = HOLD_LEN;
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= (cycle >= CALM_START && cycle < CALM_END) || $urandom_range(99) >= 38;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (header_q.size() == 0) begin
                report("unexpected transfer", 32'(o_item.status), 32'hFFFFFFFF);
            end else begin
                check_header(o_item, header_q.pop_front());
            end
        end
    end

    initial begin
        clear_parser();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        put(8'h52, 1'b1);
        put_file(F_FMT_FIRST, 8'h00);
        put_file(F_FMT_FIRST, 8'hFF);
        put_file(F_DATA_FIRST);
        put_file(F_BAD_RIFF);
        put_file(F_BAD_WAVE);
        put_file(F_SHORT_FMT);
        put_file(F_EARLY_END);
        for (int k = 0; k < 10; k++) put_file(t_file_kind'($urandom_range(6)));
        wait_drained();

        while (byte_q.size() < 750) begin
            case ($urandom_range(9))
                0, 1, 2, 3: put_file(F_FMT_FIRST);
                4, 5: put_file(F_DATA_FIRST);
                6: put_file(F_BAD_RIFF);
                7: put_file(F_SHORT_FMT);
                8: put_file(F_EARLY_END);
                default: put_file(($urandom_range(1)) ? F_NOISE : F_BAD_WAVE);
            endcase
        end
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (err_count == 0 && header_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
